/* rtl/core/ucc_pkg.sv */
// upload session crc32 checker: shared types, codes and crc helper
// used by every file of the core but ucc_if; depends on nothing else

package ucc_pkg;

   // item geometry and crc constants
   localparam int BYTES_PER_ITEM = 8;
   localparam int ITEM_DATA_W = 8 * BYTES_PER_ITEM;
   localparam logic [31:0] CRC_SEED = 32'hFFFF_FFFF;
   localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;

   // queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   // command codes as they arrive on the request channel
   localparam logic [2:0] CMD_BEGIN = 3'd0;
   localparam logic [2:0] CMD_APPEND = 3'd1;
   localparam logic [2:0] CMD_END = 3'd2;
   localparam logic [2:0] CMD_ABORT = 3'd3;
   localparam logic [2:0] CMD_APPLY = 3'd4;

   // command class decided by the front
   typedef enum logic [2:0] {
      KIND_BEGIN,
      KIND_APPEND,
      KIND_END,
      KIND_ABORT,
      KIND_APPLY,
      KIND_INVALID
   } kind_type;

   typedef enum logic [2:0] {
      ST_OK = 3'd0,
      ST_STORAGE = 3'd1,
      ST_BUSY = 3'd2,
      ST_INVALID = 3'd3,
      ST_BADSTATE = 3'd4,
      ST_RANGE = 3'd5,
      ST_CRC = 3'd6
   } status_type;

   typedef enum logic [2:0] {
      CALL_NONE = 3'd0,
      CALL_BEGIN = 3'd1,
      CALL_WRITE = 3'd2,
      CALL_COMMIT = 3'd3,
      CALL_ABORT = 3'd4
   } call_type;

   // classified request as it sits in the queue
   typedef struct packed {
      kind_type kind;
      logic begin_args_ok;
      logic count_ok;
      logic [31:0] image_size;
      logic [31:0] expected_crc;
      logic [31:0] xfer_id;
      logic [31:0] data_offset;
      logic [3:0] byte_count;
      logic [31:0] data_term;
      logic store_ok;
   } item_type;

   // one result
   typedef struct packed {
      status_type status;
      logic [31:0] bytes_taken;
      call_type store_call;
      logic session_busy;
      logic [31:0] active_id;
      logic [31:0] received_total;
   } result_type;

   // reflected crc32 over the first count bytes of data, lowest byte first
   function automatic logic [31:0] crc_bytes(input logic [31:0] crc_in,
                                             input logic [ITEM_DATA_W-1:0] data,
                                             input logic [3:0] count);
      logic [31:0] c;
      c = crc_in;
      for (int i = 0; i < BYTES_PER_ITEM; i++) begin
         if (4'(i) < count) begin
            c = c ^ {24'h0, data[8*i +: 8]};
            for (int k = 0; k < 8; k++) begin
               c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
            end
         end
      end
      return c;
   endfunction

endpackage

/* rtl/core/ucc_if.sv */
// request and result channel interfaces of the upload session checker
// plain valid/ready channels; no package dependency

interface ucc_req_if;
   logic valid;
   logic ready;
   logic [2:0] command;
   logic [31:0] image_size;
   logic [15:0] image_width;
   logic [15:0] image_height;
   logic [31:0] expected_crc;
   logic [31:0] xfer_id;
   logic [31:0] data_offset;
   logic [3:0] byte_count;
   logic [63:0] chunk_data;
   logic store_ok;

   modport source (output valid, command, image_size, image_width, image_height,
                   expected_crc, xfer_id, data_offset, byte_count, chunk_data,
                   store_ok, input ready);
   modport sink (input valid, command, image_size, image_width, image_height,
                 expected_crc, xfer_id, data_offset, byte_count, chunk_data,
                 store_ok, output ready);
endinterface

interface ucc_rsp_if;
   logic valid;
   logic ready;
   logic [2:0] status;
   logic [31:0] bytes_taken;
   logic [2:0] store_call;
   logic session_busy;
   logic [31:0] active_id;
   logic [31:0] received_total;

   modport source (output valid, status, bytes_taken, store_call, session_busy,
                   active_id, received_total, input ready);
   modport sink (input valid, status, bytes_taken, store_call, session_busy,
                 active_id, received_total, output ready);
endinterface

/* rtl/core/ucc_front.sv */
// front end: takes requests, decodes the command, runs the state-free checks
// and the data half of the crc update; uses ucc_pkg and ucc_req_if

module ucc_front (
   ucc_req_if.sink req_chan,
   output logic push_valid,
   input logic push_ready,
   output ucc_pkg::item_type push_item
);

   ucc_pkg::kind_type kind;

   // command decode
   always_comb begin
      unique case (req_chan.command)
         ucc_pkg::CMD_BEGIN: kind = ucc_pkg::KIND_BEGIN;
         ucc_pkg::CMD_APPEND: kind = ucc_pkg::KIND_APPEND;
         ucc_pkg::CMD_END: kind = ucc_pkg::KIND_END;
         ucc_pkg::CMD_ABORT: kind = ucc_pkg::KIND_ABORT;
         ucc_pkg::CMD_APPLY: kind = ucc_pkg::KIND_APPLY;
         default: kind = ucc_pkg::KIND_INVALID;
      endcase
   end

   // handshake straight through to the queue
   assign push_valid = req_chan.valid;
   assign req_chan.ready = push_ready;

   // classified request; the crc is linear, so the data term is taken from a zero state
   always_comb begin
      push_item.kind = kind;
      push_item.begin_args_ok = (req_chan.image_size != 32'h0) &&
                                (req_chan.image_width != 16'h0) &&
                                (req_chan.image_height != 16'h0);
      push_item.count_ok = (req_chan.byte_count != 4'h0) &&
                           (req_chan.byte_count <= 4'(ucc_pkg::BYTES_PER_ITEM));
      push_item.image_size = req_chan.image_size;
      push_item.expected_crc = req_chan.expected_crc;
      push_item.xfer_id = req_chan.xfer_id;
      push_item.data_offset = req_chan.data_offset;
      push_item.byte_count = req_chan.byte_count;
      push_item.data_term = ucc_pkg::crc_bytes(32'h0,
         req_chan.chunk_data[ucc_pkg::ITEM_DATA_W-1:0], req_chan.byte_count);
      push_item.store_ok = req_chan.store_ok;
   end

endmodule

/* rtl/core/ucc_queue.sv */
// short queue of classified requests between front and back
// depth from ucc_pkg::QUEUE_DEPTH; uses ucc_pkg

module ucc_queue (
   input logic clock,
   input logic reset,
   input logic push_valid,
   output logic push_ready,
   input ucc_pkg::item_type push_item,
   output logic pop_valid,
   input logic pop_ready,
   output ucc_pkg::item_type pop_item
);

   ucc_pkg::item_type entry_ff [ucc_pkg::QUEUE_DEPTH];
   logic [ucc_pkg::QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [ucc_pkg::QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [ucc_pkg::QUEUE_CNT_W-1:0] count_ff, count_in;
   logic push;
   logic pop;

   assign push_ready = (count_ff != ucc_pkg::QUEUE_CNT_W'(ucc_pkg::QUEUE_DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_item = entry_ff[rd_ptr_ff];
   assign push = push_valid && push_ready;
   assign pop = pop_valid && pop_ready;

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == ucc_pkg::QUEUE_PTR_W'(ucc_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + ucc_pkg::QUEUE_PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == ucc_pkg::QUEUE_PTR_W'(ucc_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + ucc_pkg::QUEUE_PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + ucc_pkg::QUEUE_CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - ucc_pkg::QUEUE_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

/* rtl/core/ucc_back.sv */
// back end: session state, store-attached register, command execution and
// the result register; uses ucc_pkg and ucc_rsp_if

module ucc_back (
   input logic clock,
   input logic reset,
   input logic csr_write_en,
   input logic csr_write_data,
   input logic pop_valid,
   output logic pop_ready,
   input ucc_pkg::item_type pop_item,
   ucc_rsp_if.source rsp_chan
);

   logic store_attached_ff;
   logic session_open_ff, session_open_in;
   logic [31:0] received_count_ff, received_count_in;
   logic [31:0] running_crc_ff, running_crc_in;
   logic [31:0] size_limit_ff, size_limit_in;
   logic [31:0] target_crc_ff, target_crc_in;
   logic [31:0] session_id_ff, session_id_in;
   logic rsp_valid_ff, rsp_valid_in;
   ucc_pkg::result_type result_ff, result_in;
   logic pop;
   logic [32:0] append_end;
   logic [31:0] crc_advanced;

   // a new request executes whenever the result register is free or draining
   assign pop_ready = !rsp_valid_ff || rsp_chan.ready;
   assign pop = pop_valid && pop_ready;

   // state half of the crc update, merged with the data term from the front
   assign crc_advanced = ucc_pkg::crc_bytes(running_crc_ff, '0, pop_item.byte_count) ^
                         pop_item.data_term;
   assign append_end = {1'b0, pop_item.data_offset} + {29'h0, pop_item.byte_count};

   // command execution
   always_comb begin
      session_open_in = session_open_ff;
      received_count_in = received_count_ff;
      running_crc_in = running_crc_ff;
      size_limit_in = size_limit_ff;
      target_crc_in = target_crc_ff;
      session_id_in = session_id_ff;
      result_in.status = ucc_pkg::ST_OK;
      result_in.bytes_taken = 32'h0;
      result_in.store_call = ucc_pkg::CALL_NONE;
      unique case (pop_item.kind)
         ucc_pkg::KIND_BEGIN: begin
            if (!store_attached_ff) begin
               result_in.status = ucc_pkg::ST_STORAGE;
            end else if (session_open_ff) begin
               result_in.status = ucc_pkg::ST_BUSY;
            end else if (!pop_item.begin_args_ok) begin
               result_in.status = ucc_pkg::ST_INVALID;
            end else begin
               result_in.store_call = ucc_pkg::CALL_BEGIN;
               if (!pop_item.store_ok) begin
                  result_in.status = ucc_pkg::ST_STORAGE;
               end else begin
                  session_open_in = 1'b1;
                  size_limit_in = pop_item.image_size;
                  target_crc_in = pop_item.expected_crc;
                  session_id_in = pop_item.xfer_id;
                  received_count_in = 32'h0;
                  running_crc_in = ucc_pkg::CRC_SEED;
               end
            end
         end
         ucc_pkg::KIND_APPEND: begin
            if (!session_open_ff) begin
               result_in.status = ucc_pkg::ST_BADSTATE;
            end else if (!pop_item.count_ok) begin
               result_in.status = ucc_pkg::ST_INVALID;
            end else if (pop_item.data_offset != received_count_ff) begin
               result_in.status = ucc_pkg::ST_RANGE;
            end else if (append_end > {1'b0, size_limit_ff}) begin
               result_in.status = ucc_pkg::ST_RANGE;
            end else begin
               result_in.store_call = ucc_pkg::CALL_WRITE;
               if (!pop_item.store_ok) begin
                  result_in.status = ucc_pkg::ST_STORAGE;
               end else begin
                  running_crc_in = crc_advanced;
                  received_count_in = append_end[31:0];
                  result_in.bytes_taken = {28'h0, pop_item.byte_count};
               end
            end
         end
         ucc_pkg::KIND_END: begin
            if (!session_open_ff) begin
               result_in.status = ucc_pkg::ST_BADSTATE;
            end else begin
               result_in.bytes_taken = received_count_ff;
               if (received_count_ff != size_limit_ff) begin
                  result_in.status = ucc_pkg::ST_RANGE;
               end else if ((running_crc_ff ^ ucc_pkg::CRC_SEED) != target_crc_ff) begin
                  result_in.store_call = ucc_pkg::CALL_ABORT;
                  result_in.status = ucc_pkg::ST_CRC;
                  session_open_in = 1'b0;
               end else begin
                  result_in.store_call = ucc_pkg::CALL_COMMIT;
                  result_in.status = pop_item.store_ok ? ucc_pkg::ST_OK : ucc_pkg::ST_STORAGE;
                  session_open_in = 1'b0;
               end
            end
         end
         ucc_pkg::KIND_ABORT: begin
            if (!session_open_ff) begin
               result_in.status = ucc_pkg::ST_BADSTATE;
            end else begin
               result_in.store_call = ucc_pkg::CALL_ABORT;
               session_open_in = 1'b0;
               received_count_in = 32'h0;
               running_crc_in = ucc_pkg::CRC_SEED;
               result_in.status = pop_item.store_ok ? ucc_pkg::ST_OK : ucc_pkg::ST_STORAGE;
            end
         end
         ucc_pkg::KIND_APPLY: begin
            result_in.status = session_open_ff ? ucc_pkg::ST_BUSY : ucc_pkg::ST_OK;
         end
         default: begin
            result_in.status = ucc_pkg::ST_INVALID;
         end
      endcase
      result_in.session_busy = session_open_in;
      result_in.active_id = session_open_in ? session_id_in : 32'h0;
      result_in.received_total = received_count_in;
   end

   // result register valid
   always_comb begin
      if (pop) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // configuration and session state
   always_ff @(posedge clock) begin
      if (reset) begin
         store_attached_ff <= 1'b1;
         session_open_ff <= 1'b0;
         received_count_ff <= 32'h0;
         running_crc_ff <= ucc_pkg::CRC_SEED;
         size_limit_ff <= 32'h0;
         target_crc_ff <= 32'h0;
         session_id_ff <= 32'h0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write_en) begin
            store_attached_ff <= csr_write_data;
         end
         if (pop) begin
            session_open_ff <= session_open_in;
            received_count_ff <= received_count_in;
            running_crc_ff <= running_crc_in;
            size_limit_ff <= size_limit_in;
            target_crc_ff <= target_crc_in;
            session_id_ff <= session_id_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (pop) begin
         result_ff <= result_in;
      end
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.status = result_ff.status;
   assign rsp_chan.bytes_taken = result_ff.bytes_taken;
   assign rsp_chan.store_call = result_ff.store_call;
   assign rsp_chan.session_busy = result_ff.session_busy;
   assign rsp_chan.active_id = result_ff.active_id;
   assign rsp_chan.received_total = result_ff.received_total;

endmodule

/* rtl/core/upload_session_crc32_checker_core.sv */
// a request accepted at an edge is written to the queue; from the queue it is executed into
// the result register, where the result turns valid
// throughput: one request per cycle, the back end executing one queued request
// a cycle while the result register drains; the crc of 8 bytes is combinational
// reset: synchronous, active high; session closed, count zero, crc seeded,
// store attached, queue and result register empty

module upload_session_crc32_checker_core (
   input logic clock,
   input logic reset,
   input logic csr_write_en,
   input logic csr_write_data,
   ucc_req_if.sink req_chan,
   ucc_rsp_if.source rsp_chan
);

   logic push_valid;
   logic push_ready;
   ucc_pkg::item_type push_item;
   logic pop_valid;
   logic pop_ready;
   ucc_pkg::item_type pop_item;

   // decode and state-free checks
   ucc_front u_front (
      .req_chan(req_chan),
      .push_valid(push_valid),
      .push_ready(push_ready),
      .push_item(push_item)
   );

   // decoupling queue
   ucc_queue u_queue (
      .clock(clock),
      .reset(reset),
      .push_valid(push_valid),
      .push_ready(push_ready),
      .push_item(push_item),
      .pop_valid(pop_valid),
      .pop_ready(pop_ready),
      .pop_item(pop_item)
   );

   // session execution and result register
   ucc_back u_back (
      .clock(clock),
      .reset(reset),
      .csr_write_en(csr_write_en),
      .csr_write_data(csr_write_data),
      .pop_valid(pop_valid),
      .pop_ready(pop_ready),
      .pop_item(pop_item),
      .rsp_chan(rsp_chan)
   );

endmodule

/* rtl/core/ucc_checker.sv */
// port-level checks on the upload session checker core and their binding
// uses ucc_pkg codes; attaches to upload_session_crc32_checker_core

module ucc_checker (
   input logic clock,
   input logic reset,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic [2:0] rsp_status,
   input logic [31:0] rsp_bytes_taken,
   input logic [2:0] rsp_store_call,
   input logic rsp_session_busy,
   input logic [31:0] rsp_active_id,
   input logic [31:0] rsp_received_total
);

   // no result straight after reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // a stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) &&
      $stable(rsp_received_total))
      else $error("stalled result changed");

   // closed session shows no id
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_session_busy |-> rsp_active_id == 32'h0)
      else $error("id shown without open session");

   // a successful begin opens an empty session
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_store_call == ucc_pkg::CALL_BEGIN && rsp_status == ucc_pkg::ST_OK
      |-> rsp_session_busy && rsp_received_total == 32'h0)
      else $error("begin did not open an empty session");

   // a successful write moves one to eight bytes and keeps the session
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_store_call == ucc_pkg::CALL_WRITE && rsp_status == ucc_pkg::ST_OK
      |-> rsp_session_busy && rsp_bytes_taken != 32'h0 &&
          rsp_bytes_taken <= 32'(ucc_pkg::BYTES_PER_ITEM))
      else $error("write accepted a bad byte count");

endmodule

bind upload_session_crc32_checker_core ucc_checker u_ucc_checker (
   .clock(clock),
   .reset(reset),
   .rsp_valid(rsp_chan.valid),
   .rsp_ready(rsp_chan.ready),
   .rsp_status(rsp_chan.status),
   .rsp_bytes_taken(rsp_chan.bytes_taken),
   .rsp_store_call(rsp_chan.store_call),
   .rsp_session_busy(rsp_chan.session_busy),
   .rsp_active_id(rsp_chan.active_id),
   .rsp_received_total(rsp_chan.received_total)
);
